// File: rtl/tkm_pkg.sv
// Package for the timestamp k-way merge: sizes, channel structs, queue command
// format, back-end state codes and the candidate compare function.
// No dependencies.
package tkm_pkg;

    localparam int NUM_SOURCES = 16;
    localparam int TIME_BITS   = 48;
    localparam int SRC_BITS    = 4;
    localparam int IDX_BITS    = $clog2(NUM_SOURCES);
    localparam int CFG_BITS    = 5;
    localparam int GRP_SIZE    = 4;
    localparam int NUM_GRP     = NUM_SOURCES / GRP_SIZE;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_BITS-1:0] ACTIVE_RESET = CFG_BITS'(NUM_SOURCES);

    localparam logic OP_HIT = 1'b0;
    localparam logic OP_END = 1'b1;

    typedef struct packed {
        logic                 opcode;
        logic [SRC_BITS-1:0]  source_index;
        logic [7:0]           board;
        logic [5:0]           channel;
        logic [15:0]          energy;
        logic [15:0]          energy_short;
        logic [47:0]          timestamp;
        logic [31:0]          flags;
    } in_t;

    typedef struct packed {
        logic [7:0]           out_board;
        logic [5:0]           out_channel;
        logic [15:0]          out_energy;
        logic [15:0]          out_energy_short;
        logic [47:0]          out_timestamp;
        logic [31:0]          out_flags;
        logic [SRC_BITS-1:0]  out_source;
        logic                 last;
    } out_t;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_HIT,
        CMD_END
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t            kind;
        logic [IDX_BITS-1:0]  src;
        logic [7:0]           board;
        logic [5:0]           channel;
        logic [15:0]          energy;
        logic [15:0]          energy_short;
        logic [TIME_BITS-1:0] timestamp;
        logic [31:0]          flags;
    } cmd_t;

    typedef struct packed {
        logic                 found;
        logic [IDX_BITS-1:0]  idx;
        logic [TIME_BITS-1:0] ts;
    } cand_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_TREE,
        BK_PICK,
        BK_EMIT
    } bk_state_t;

    // keep a unless b is strictly earlier, so the lower index wins ties
    function automatic cand_t cand_min(cand_t a, cand_t b);
        cand_t r;
        r = a;
        if (b.found && (!a.found || (b.ts < a.ts))) begin
            r = b;
        end
        return r;
    endfunction

endpackage

// File: rtl/tkm_front.sv
// Front end of the timestamp merge: takes input transactions, range-checks the
// source and turns each into a queue command. Depends on tkm_pkg.
module tkm_front (
    input  logic                          s_valid,
    output logic                          s_ready,
    input  tkm_pkg::in_t                  s_data,
    input  logic [tkm_pkg::CFG_BITS-1:0]  active_count,
    output logic                          push_valid,
    input  logic                          push_ready,
    output tkm_pkg::cmd_t                 push_data
);

    logic in_range;

    assign in_range   = {1'b0, s_data.source_index} < active_count;
    assign s_ready    = push_ready;
    assign push_valid = s_valid;

    always_comb begin
        push_data.src          = tkm_pkg::IDX_BITS'(s_data.source_index);
        push_data.board        = s_data.board;
        push_data.channel      = s_data.channel;
        push_data.energy       = s_data.energy;
        push_data.energy_short = s_data.energy_short;
        push_data.timestamp    = s_data.timestamp[tkm_pkg::TIME_BITS-1:0];
        push_data.flags        = s_data.flags;
        if (!in_range) begin
            push_data.kind = tkm_pkg::CMD_NONE;
        end else if (s_data.opcode == tkm_pkg::OP_END) begin
            push_data.kind = tkm_pkg::CMD_END;
        end else begin
            push_data.kind = tkm_pkg::CMD_HIT;
        end
    end

endmodule

// File: rtl/tkm_queue.sv
// Short command queue between the front and back ends of the merge.
// Depends on tkm_pkg.
module tkm_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  tkm_pkg::cmd_t  push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output tkm_pkg::cmd_t  pop_data
);

    tkm_pkg::cmd_t                  entry_reg [tkm_pkg::QUEUE_DEPTH];
    logic [tkm_pkg::QPTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [tkm_pkg::QPTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [tkm_pkg::QCNT_BITS-1:0]  count_reg, count_next;
    logic                           do_push, do_pop;

    assign push_ready = count_reg != tkm_pkg::QCNT_BITS'(tkm_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == tkm_pkg::QPTR_BITS'(tkm_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == tkm_pkg::QPTR_BITS'(tkm_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/tkm_back.sv
// Back end of the timestamp merge: head store, valid and done flags, a
// registered two-level minimum search and the result register. Depends on tkm_pkg.
module tkm_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [tkm_pkg::CFG_BITS-1:0]  active_count,
    input  logic                          pop_valid,
    output logic                          pop_ready,
    input  tkm_pkg::cmd_t                 pop_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output tkm_pkg::out_t                 m_data
);

    localparam int N = tkm_pkg::NUM_SOURCES;

    logic [tkm_pkg::TIME_BITS-1:0] head_time_reg     [N];
    logic [31:0]                   head_energies_reg [N];
    logic [45:0]                   head_tag_reg      [N];

    logic [N-1:0]          valid_reg, valid_next;
    logic [N-1:0]          done_reg, done_next;
    tkm_pkg::bk_state_t    state_reg, state_next;
    tkm_pkg::cand_t        grp_reg [tkm_pkg::NUM_GRP];
    tkm_pkg::cand_t        grp_next [tkm_pkg::NUM_GRP];
    tkm_pkg::cand_t        best_reg, best_next;
    logic                  ready_reg, ready_next;
    logic                  m_valid_reg, m_valid_next;
    tkm_pkg::out_t         m_data_reg, m_data_next;

    logic [N-1:0]          active_mask;
    tkm_pkg::cand_t        leaf [N];
    logic                  head_we;
    logic [N-1:0]          best_onehot;
    logic [N-1:0]          remain;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        for (int i = 0; i < N; i++) begin
            active_mask[i] = tkm_pkg::CFG_BITS'(i) < active_count;
            leaf[i].found  = valid_reg[i] && active_mask[i];
            leaf[i].idx    = tkm_pkg::IDX_BITS'(i);
            leaf[i].ts     = head_time_reg[i];
        end
    end

    always_comb begin
        for (int g = 0; g < tkm_pkg::NUM_GRP; g++) begin
            grp_next[g] = leaf[g * tkm_pkg::GRP_SIZE];
            for (int k = 1; k < tkm_pkg::GRP_SIZE; k++) begin
                grp_next[g] = tkm_pkg::cand_min(grp_next[g], leaf[g * tkm_pkg::GRP_SIZE + k]);
            end
        end
        best_next = grp_reg[0];
        for (int g = 1; g < tkm_pkg::NUM_GRP; g++) begin
            best_next = tkm_pkg::cand_min(best_next, grp_reg[g]);
        end
    end

    assign best_onehot = {{(N-1){1'b0}}, 1'b1} << best_reg.idx;
    assign remain      = valid_reg & active_mask & ~best_onehot;

    always_comb begin
        state_next   = state_reg;
        valid_next   = valid_reg;
        done_next    = done_reg;
        ready_next   = ready_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        pop_ready    = 1'b0;
        head_we      = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            tkm_pkg::BK_IDLE: begin
                pop_ready = 1'b1;
                if (pop_valid) begin
                    if (pop_data.kind == tkm_pkg::CMD_END) begin
                        done_next[pop_data.src] = 1'b1;
                    end else if (pop_data.kind == tkm_pkg::CMD_HIT
                                 && !done_reg[pop_data.src]
                                 && !valid_reg[pop_data.src]) begin
                        head_we                  = 1'b1;
                        valid_next[pop_data.src] = 1'b1;
                    end
                    state_next = tkm_pkg::BK_TREE;
                end
            end
            tkm_pkg::BK_TREE: begin
                ready_next = &(valid_reg | done_reg | ~active_mask);
                state_next = tkm_pkg::BK_PICK;
            end
            tkm_pkg::BK_PICK: begin
                state_next = tkm_pkg::BK_EMIT;
            end
            tkm_pkg::BK_EMIT: begin
                if (!ready_reg || !best_reg.found) begin
                    state_next = tkm_pkg::BK_IDLE;
                end else if (!m_valid_reg || m_ready) begin
                    m_valid_next                 = 1'b1;
                    m_data_next.out_board        = head_tag_reg[best_reg.idx][45:38];
                    m_data_next.out_channel      = head_tag_reg[best_reg.idx][37:32];
                    m_data_next.out_flags        = head_tag_reg[best_reg.idx][31:0];
                    m_data_next.out_energy       = head_energies_reg[best_reg.idx][31:16];
                    m_data_next.out_energy_short = head_energies_reg[best_reg.idx][15:0];
                    m_data_next.out_timestamp    = 48'(head_time_reg[best_reg.idx]);
                    m_data_next.out_source       = tkm_pkg::SRC_BITS'(best_reg.idx);
                    m_data_next.last             = (remain == '0)
                                                 && (&(done_reg | ~active_mask));
                    valid_next                   = valid_reg & ~best_onehot;
                    state_next                   = tkm_pkg::BK_IDLE;
                end
            end
            default: begin
                state_next = tkm_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tkm_pkg::BK_IDLE;
            valid_reg   <= '0;
            done_reg    <= '0;
            ready_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            done_reg    <= done_next;
            ready_reg   <= ready_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (state_reg == tkm_pkg::BK_TREE) begin
            grp_reg <= grp_next;
        end
        if (state_reg == tkm_pkg::BK_PICK) begin
            best_reg <= best_next;
        end
        if (head_we) begin
            head_time_reg[pop_data.src]     <= pop_data.timestamp;
            head_energies_reg[pop_data.src] <= {pop_data.energy, pop_data.energy_short};
            head_tag_reg[pop_data.src]      <= {pop_data.board, pop_data.channel,
                                                pop_data.flags};
        end
    end

endmodule

// File: rtl/timestamp_kway_merge.sv
// Timestamp k-way merge of detector hit streams, top level.
// An accepted input passes through the queue and the head store; the group minima, the
// final minimum and the result are then registered in turn (back end idle, output free).
// The back end takes a new command only after its sequence of head update, group minimum,
// final minimum and emit, which waits on the output; a full queue holds input off.
// Reset (aresetn, synchronous): clears valid/done flags, queue and output; active_sources = 16.
// Depends on tkm_pkg, tkm_front, tkm_queue, tkm_back.
module timestamp_kway_merge (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [tkm_pkg::CFG_BITS-1:0]  cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  tkm_pkg::in_t                  s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output tkm_pkg::out_t                 m_data
);

    logic [tkm_pkg::CFG_BITS-1:0] active_sources_reg;
    logic [tkm_pkg::CFG_BITS-1:0] active_count;
    logic                         push_valid, push_ready;
    logic                         pop_valid, pop_ready;
    tkm_pkg::cmd_t                push_data, pop_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_sources_reg <= tkm_pkg::ACTIVE_RESET;
        end else if (cfg_wr_en) begin
            active_sources_reg <= cfg_wr_data;
        end
    end

    // clamp to the range 1 .. NUM_SOURCES
    always_comb begin
        if (active_sources_reg == '0) begin
            active_count = tkm_pkg::CFG_BITS'(1);
        end else if (active_sources_reg > tkm_pkg::CFG_BITS'(tkm_pkg::NUM_SOURCES)) begin
            active_count = tkm_pkg::CFG_BITS'(tkm_pkg::NUM_SOURCES);
        end else begin
            active_count = active_sources_reg;
        end
    end

    tkm_front u_front (
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .active_count (active_count),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_data    (push_data)
    );

    tkm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    tkm_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .active_count (active_count),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_data     (pop_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data)
    );

endmodule

// File: tb/sv/tb_top.sv
// Testbench for timestamp_kway_merge: a table of directed transactions, then random
// merge phases across several source counts; each result is checked against a typed value or a merge predictor.
// Depends on tkm_pkg and the timestamp_kway_merge RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 24;
    localparam int TAIL_CYCLES   = 40;
    localparam int NUM_PHASES    = 9;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_TYPED} check_t;

    typedef struct {
        row_kind_t                    kind;
        tkm_pkg::in_t                 item;
        check_t                       chk;
        tkm_pkg::out_t                typed;
        logic [tkm_pkg::CFG_BITS-1:0] cfg;
    } directed_row_t;

    logic                         aclk        = 1'b0;
    logic                         aresetn     = 1'b0;
    logic                         cfg_wr_en   = 1'b0;
    logic [tkm_pkg::CFG_BITS-1:0] cfg_wr_data = '0;
    logic                         s_valid     = 1'b0;
    logic                         s_ready;
    tkm_pkg::in_t                 s_data      = '0;
    logic                         m_valid;
    logic                         m_ready     = 1'b0;
    tkm_pkg::out_t                m_data;

    tkm_pkg::in_t                    head_hit [tkm_pkg::NUM_SOURCES];
    logic [tkm_pkg::NUM_SOURCES-1:0] head_held  = '0;
    logic [tkm_pkg::NUM_SOURCES-1:0] src_closed = '0;
    logic [tkm_pkg::CFG_BITS-1:0]    active_reg = tkm_pkg::ACTIVE_RESET;
    logic [47:0]                     ts_base    = '0;

    tkm_pkg::out_t pending_hits [$];
    directed_row_t directed_rows [$];
    int            mismatch_count = 0;
    int            calm_items     = 0;
    int            ready_hold     = 0;
    int            ready_roll     = 0;
    tkm_pkg::out_t want;

    int phase_cfg   [NUM_PHASES] = '{16, 9, 31, 6, 12, 16, 14, 16, 1};
    int phase_len   [NUM_PHASES] = '{420, 200, 200, 150, 300, 200, 100, 200, 20};
    bit phase_close [NUM_PHASES] = '{0, 0, 0, 1, 1, 0, 1, 1, 0};

    timestamp_kway_merge dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    initial begin
        #12_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic int span_of(input logic [tkm_pkg::CFG_BITS-1:0] v);
        if (v == 0) return 1;
        if (v > tkm_pkg::NUM_SOURCES) return tkm_pkg::NUM_SOURCES;
        return int'(v);
    endfunction

    function automatic tkm_pkg::in_t hit_item(input logic [tkm_pkg::SRC_BITS-1:0] src,
                                              input logic [47:0] ts,
                                              input logic [7:0] board,
                                              input logic [5:0] channel,
                                              input logic [15:0] energy,
                                              input logic [15:0] energy_short,
                                              input logic [31:0] flags);
        tkm_pkg::in_t it;
        it.opcode       = tkm_pkg::OP_HIT;
        it.source_index = src;
        it.board        = board;
        it.channel      = channel;
        it.energy       = energy;
        it.energy_short = energy_short;
        it.timestamp    = ts;
        it.flags        = flags;
        return it;
    endfunction

    function automatic tkm_pkg::in_t end_item(input logic [tkm_pkg::SRC_BITS-1:0] src);
        tkm_pkg::in_t it;
        it = hit_item(src, {16'($urandom), 32'($urandom)}, 8'($urandom), 6'($urandom),
                      16'($urandom), 16'($urandom), $urandom);
        it.opcode = tkm_pkg::OP_END;
        return it;
    endfunction

    function automatic tkm_pkg::in_t random_hit(input logic [tkm_pkg::SRC_BITS-1:0] src);
        int          r;
        logic [47:0] ts;
        r = $urandom_range(0, 99);
        ts_base = ts_base + 48'($urandom_range(0, 2));
        if (r < 8) begin
            ts = {16'($urandom), 32'($urandom)};
        end else if (r < 10) begin
            ts = '1;
        end else if (r < 12) begin
            ts = '0;
        end else begin
            ts = ts_base + 48'($urandom_range(0, 3));
        end
        return hit_item(src, ts, 8'($urandom), 6'($urandom), 16'($urandom), 16'($urandom),
                        $urandom);
    endfunction

    function automatic tkm_pkg::out_t as_result(input tkm_pkg::in_t it,
                                                input logic [tkm_pkg::SRC_BITS-1:0] src,
                                                input logic fin);
        tkm_pkg::out_t r;
        r.out_board        = it.board;
        r.out_channel      = it.channel;
        r.out_energy       = it.energy;
        r.out_energy_short = it.energy_short;
        r.out_timestamp    = it.timestamp;
        r.out_flags        = it.flags;
        r.out_source       = src;
        r.last             = fin;
        return r;
    endfunction

    function automatic bit merge_predict(input tkm_pkg::in_t it, output tkm_pkg::out_t res);
        int n;
        int best;
        bit all_ready;
        bit found;
        bit fin;
        n = span_of(active_reg);
        all_ready = 1'b1;
        found = 1'b0;
        best = 0;
        fin = 1'b1;
        res = '0;
        if (int'(it.source_index) < n) begin
            if (it.opcode == tkm_pkg::OP_END) begin
                src_closed[it.source_index] = 1'b1;
            end else if (!src_closed[it.source_index] && !head_held[it.source_index]) begin
                head_hit[it.source_index]  = it;
                head_held[it.source_index] = 1'b1;
            end
        end
        for (int i = 0; i < n; i++) begin
            if (head_held[i]) begin
                if (!found || head_hit[i].timestamp < head_hit[best].timestamp) begin
                    best = i;
                    found = 1'b1;
                end
            end else if (!src_closed[i]) begin
                all_ready = 1'b0;
            end
        end
        if (!all_ready || !found) return 1'b0;
        head_held[best] = 1'b0;
        for (int i = 0; i < n; i++) begin
            if (head_held[i] || !src_closed[i]) fin = 1'b0;
        end
        res = as_result(head_hit[best], tkm_pkg::SRC_BITS'(best), fin);
        return 1'b1;
    endfunction

    task automatic put(input row_kind_t kind, input tkm_pkg::in_t it, input check_t chk,
                       input tkm_pkg::out_t typed, input logic [tkm_pkg::CFG_BITS-1:0] v);
        directed_row_t row;
        row.kind  = kind;
        row.item  = it;
        row.chk   = chk;
        row.typed = typed;
        row.cfg   = v;
        directed_rows.push_back(row);
    endtask

    task automatic build_directed();
        tkm_pkg::in_t it;
        logic [47:0]  ts;
        for (int i = 1; i < tkm_pkg::NUM_SOURCES; i++) begin
            if (i <= 2) ts = 48'h10;
            else if (i == tkm_pkg::NUM_SOURCES - 1) ts = '1;
            else ts = 48'(i) << 12;
            it = hit_item(tkm_pkg::SRC_BITS'(i), ts, 8'(i * 17), 6'(i * 4 + 1), 16'(i * 4099),
                          16'(~(i * 4099)), 32'h0101_0101 * i);
            put(ROW_ITEM, it, CHK_NONE, '0, '0);
        end
        it = hit_item(4'd0, 48'h0, 8'hFF, 6'h3F, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF);
        put(ROW_ITEM, it, CHK_TYPED, as_result(it, 4'd0, 1'b0), '0);
        put(ROW_CFG, '0, CHK_NONE, '0, 5'd0);
        it = hit_item(4'd0, '1, 8'h00, 6'h00, 16'h0000, 16'hFFFF, 32'h0000_0000);
        put(ROW_ITEM, it, CHK_TYPED, as_result(it, 4'd0, 1'b0), '0);
        it = hit_item(4'd7, 48'h20, 8'h5A, 6'h15, 16'h1234, 16'h4321, 32'hA5A5_5A5A);
        put(ROW_ITEM, it, CHK_NONE, '0, '0);
        put(ROW_ITEM, end_item(4'd0), CHK_NONE, '0, '0);
        it = hit_item(4'd0, 48'h30, 8'h11, 6'h22, 16'h3333, 16'h4444, 32'h5555_6666);
        put(ROW_ITEM, it, CHK_NONE, '0, '0);
        put(ROW_CFG, '0, CHK_NONE, '0, 5'd31);
        it = hit_item(4'd3, 48'h1, 8'h77, 6'h07, 16'h7777, 16'h0777, 32'h7777_7777);
        put(ROW_ITEM, it, CHK_MODEL, '0, '0);
        put(ROW_CFG, '0, CHK_NONE, '0, 5'd4);
        put(ROW_ITEM, end_item(4'd2), CHK_NONE, '0, '0);
        put(ROW_ITEM, end_item(4'd3), CHK_NONE, '0, '0);
        put(ROW_ITEM, end_item(4'd1), CHK_MODEL, '0, '0);
        put(ROW_ITEM, end_item(4'd3), CHK_MODEL, '0, '0);
        put(ROW_ITEM, end_item(4'd2), CHK_NONE, '0, '0);
    endtask

    task automatic issue(input tkm_pkg::in_t it, input check_t chk, input tkm_pkg::out_t typed);
        tkm_pkg::out_t predicted;
        bit            got;
        s_data  <= it;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        got = merge_predict(it, predicted);
        if (chk == CHK_TYPED) begin
            pending_hits.push_back(typed);
        end else if (chk == CHK_MODEL && got) begin
            pending_hits.push_back(predicted);
        end
    endtask

    task automatic pause_sender();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (calm_items > 0) begin
            calm_items--;
            n = 0;
        end else if (r < 50) begin
            n = 0;
        end else if (r < 85) begin
            n = $urandom_range(1, 3);
        end else if (r < 97) begin
            n = $urandom_range(4, 12);
        end else begin
            n = $urandom_range(20, 40);
        end
        if ($urandom_range(0, 99) == 0) calm_items = $urandom_range(30, 80);
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_hits.size() != 0) @(posedge aclk);
    endtask

    task automatic write_active(input logic [tkm_pkg::CFG_BITS-1:0] v);
        drain_results();
        // let items that give no result clear the pipeline first
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        active_reg = v;
    endtask

    task automatic run_phase(input logic [tkm_pkg::CFG_BITS-1:0] v, input int len,
                             input bit close);
        int                           n;
        int                           r;
        int                           pick;
        int                           held;
        logic [tkm_pkg::SRC_BITS-1:0] src;
        int                           open_slots [$];
        int                           live [$];
        tkm_pkg::in_t                 it;
        write_active(v);
        n = span_of(v);
        for (int k = 0; k < len; k++) begin
            open_slots.delete();
            live.delete();
            for (int i = 0; i < n; i++) begin
                if (!src_closed[i]) begin
                    live.push_back(i);
                    if (!head_held[i]) open_slots.push_back(i);
                end
            end
            r = $urandom_range(0, 99);
            if (r < 80 && live.size() != 0) begin
                if (open_slots.size() != 0) begin
                    src = tkm_pkg::SRC_BITS'(open_slots[$urandom_range(0, open_slots.size() - 1)]);
                end else begin
                    src = tkm_pkg::SRC_BITS'(live[$urandom_range(0, live.size() - 1)]);
                end
                it = random_hit(src);
            end else if (r < 96) begin
                it = random_hit(tkm_pkg::SRC_BITS'($urandom_range(0, 15)));
            end else begin
                src = tkm_pkg::SRC_BITS'($urandom_range(0, 15));
                it = (src < n && !src_closed[src]) ? random_hit(src) : end_item(src);
            end
            if ($urandom_range(0, 149) == 0) drain_results();
            pause_sender();
            issue(it, CHK_MODEL, '0);
        end
        if (close) begin
            live.delete();
            for (int i = 0; i < n; i++) begin
                if (!src_closed[i]) live.push_back(i);
            end
            while (live.size() != 0) begin
                pick = $urandom_range(0, live.size() - 1);
                pause_sender();
                issue(end_item(tkm_pkg::SRC_BITS'(live[pick])), CHK_MODEL, '0);
                live.delete(pick);
            end
            // drain leftover heads, then one more step with nothing held
            forever begin
                held = 0;
                for (int i = 0; i < n; i++) held += head_held[i];
                if (held == 0) break;
                pause_sender();
                issue(end_item(tkm_pkg::SRC_BITS'($urandom_range(0, n - 1))), CHK_MODEL, '0);
            end
            pause_sender();
            issue(end_item(tkm_pkg::SRC_BITS'($urandom_range(0, n - 1))), CHK_MODEL, '0);
        end
    endtask

    task automatic check_field(input string what, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s expected %h actual %h", $time, what, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            ready_roll = $urandom_range(0, 99);
            if (ready_roll < 55) begin
                m_ready    <= 1'b1;
                ready_hold <= $urandom_range(0, 3);
            end else if (ready_roll < 85) begin
                m_ready    <= 1'b0;
                ready_hold <= $urandom_range(0, 3);
            end else if (ready_roll < 95) begin
                m_ready    <= 1'b1;
                ready_hold <= $urandom_range(20, 80);
            end else begin
                m_ready    <= 1'b0;
                ready_hold <= $urandom_range(10, 40);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_hits.size() == 0) begin
                $display("%0t: result with none expected, actual %h", $time, m_data);
                mismatch_count++;
            end else begin
                want = pending_hits.pop_front();
                check_field("out_board", want.out_board, m_data.out_board);
                check_field("out_channel", want.out_channel, m_data.out_channel);
                check_field("out_energy", want.out_energy, m_data.out_energy);
                check_field("out_energy_short", want.out_energy_short, m_data.out_energy_short);
                check_field("out_timestamp", want.out_timestamp, m_data.out_timestamp);
                check_field("out_flags", want.out_flags, m_data.out_flags);
                check_field("out_source", want.out_source, m_data.out_source);
                check_field("last", want.last, m_data.last);
            end
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        build_directed();
        foreach (directed_rows[k]) begin
            if (directed_rows[k].kind == ROW_CFG) begin
                write_active(directed_rows[k].cfg);
            end else begin
                pause_sender();
                issue(directed_rows[k].item, directed_rows[k].chk, directed_rows[k].typed);
            end
        end
        for (int p = 0; p < NUM_PHASES; p++) begin
            run_phase(tkm_pkg::CFG_BITS'(phase_cfg[p]), phase_len[p], phase_close[p]);
        end
        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
